>>> rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the moving-average block.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int WIN_W    = 9;
  localparam int SUM_W    = 64;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(100);

  localparam logic [SAMPLE_W-1:0] MEAN_MAX = 32'h7fff_ffff;
  localparam logic [SAMPLE_W-1:0] MEAN_MIN = 32'h8000_0000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [WIN_W-1:0]    win_t;
  typedef logic        [SUM_W-1:0]    sum_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DELIVER
  } swm_state_t;

endpackage

>>> rtl/swm_ram.sv
// ----------------------------------------------------------------------------
// swm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swm_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/swm_divider.sv
// ----------------------------------------------------------------------------
// swm_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swm_divider (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  swm_pkg::sum_t dividend,
  input  swm_pkg::win_t divisor,
  output logic          done,
  output swm_pkg::sum_t quotient
);
  import swm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  win_t              dvsr;
  win_t              rem;
  sum_t              quo;

  logic [WIN_W:0]    rem_sh;
  logic              ge;

  // shift in the next dividend bit and try a subtract
  assign rem_sh = {rem, quo[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= ge ? WIN_W'(rem_sh - {1'b0, dvsr}) : rem_sh[WIN_W-1:0];
      quo <= {quo[SUM_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

>>> rtl/sliding_window_mean.sv
// ----------------------------------------------------------------------------
// sliding_window_mean
// Simple moving average over a stream of signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Input channel s_*: one transfer carries a sample (s_tdata) and a flag that
// starts a new series (s_tuser). Output channel m_*: one transfer per input,
// the mean (m_tdata) and its valid flag (m_tuser). During warm-up, the first
// window_length samples of a series, the flag is 0 and the mean is 0.
// cfg_wr_en / cfg_wr_data write window_length; 0 acts as 1, values above
// MAX_WINDOW saturate. Write it only while the block is idle.
//
// Samples live in a MAX_WINDOW x 32 RAM; the sample leaving the window is
// read in the cycle after the input transfer and the new one written at its end.
// An input transfer moves the FSM to ST_UPDATE, then to ST_DIVIDE for a
// mean, then to ST_DELIVER, which loads the output register. The mean comes
// from a 64-step restoring divider (one quotient bit per cycle). A new
// sample is taken only after the last one has left ST_DELIVER.
// The finished result sits in an output register, so the next input is
// taken while the receiver stalls; processing stops only when a second
// result would overwrite it.
// Reset clears the sum, the count and the write slot and sets the window to
// 100. The RAM is not cleared: an entry's read data is used only after it was written.
// ----------------------------------------------------------------------------
module sliding_window_mean #(
  parameter int MAX_WINDOW = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_wr_en,
  input  swm_pkg::win_t          cfg_wr_data,  // window_length
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [31:0]            s_tdata,      // [31:0] sample
  input  logic                   s_tuser,      // [0] series_start
  // output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata,      // [31:0] mean
  output logic                   m_tuser       // [0] mean_valid
);
  import swm_pkg::*;

  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int CW   = ((AW > WIN_W) ? AW : WIN_W) + 1;
  localparam int WCAP = (MAX_WINDOW > (2**WIN_W - 1)) ? (2**WIN_W - 1) : MAX_WINDOW;

  swm_state_t state, state_next;

  win_t            win_len;
  win_t            win;
  logic [AW-1:0]   slot;
  sum_t            sum;
  win_t            count;
  sample_t         smp;
  logic            new_series;
  logic            res_valid;
  logic            neg;

  logic [CW-1:0]   slot_x;
  logic [CW-1:0]   win_x;
  logic [CW-1:0]   old_x;
  logic [AW-1:0]   rd_addr;
  logic [31:0]     rd_data;

  sum_t            base_sum;
  win_t            base_cnt;
  logic            full;
  logic [32:0]     delta;
  sum_t            sum_new;
  sum_t            sum_mag;

  logic            accept;
  logic            out_free;
  logic            do_update;
  logic            div_start;
  logic            div_done;
  sum_t            quotient;
  logic            q_over;
  logic [31:0]     mean_res;

  // effective window
  always_comb begin
    if (win_len == '0) begin
      win = WIN_W'(1);
    end else if (win_len > WIN_W'(WCAP)) begin
      win = WIN_W'(WCAP);
    end else begin
      win = win_len;
    end
  end

  // slot of the sample written win items ago
  assign slot_x  = CW'(slot);
  assign win_x   = CW'(win);
  assign old_x   = (slot_x >= win_x) ? slot_x - win_x : slot_x + CW'(MAX_WINDOW) - win_x;
  assign rd_addr = old_x[AW-1:0];

  swm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (do_update),
    .wr_addr (slot),
    .wr_data (smp),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // read-modify-write of the sum and count
  assign base_sum = new_series ? '0 : sum;
  assign base_cnt = new_series ? '0 : count;
  assign full     = base_cnt >= win;
  assign delta    = {smp[SAMPLE_W-1], smp} - (full ? {rd_data[31], rd_data} : 33'd0);
  assign sum_new  = base_sum + {{(SUM_W-33){delta[32]}}, delta};
  assign sum_mag  = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : sum_new;

  assign div_start = do_update && full;

  swm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (win),
    .done     (div_done),
    .quotient (quotient)
  );

  // saturate to the signed 32-bit range
  always_comb begin
    q_over = neg ? ((|quotient[SUM_W-1:32]) || (quotient[31] && (|quotient[30:0])))
                 : ((|quotient[SUM_W-1:32]) || quotient[31]);
    if (!res_valid) begin
      mean_res = '0;
    end else if (q_over) begin
      mean_res = neg ? MEAN_MIN : MEAN_MAX;
    end else begin
      mean_res = neg ? 32'(-quotient[31:0]) : quotient[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    do_update  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        do_update  = 1'b1;
        state_next = full ? ST_DIVIDE : ST_DELIVER;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len <= WINDOW_RESET;
      slot    <= '0;
      sum     <= '0;
      count   <= '0;
    end else begin
      if (cfg_wr_en) begin
        win_len <= cfg_wr_data;
      end
      if (do_update) begin
        sum   <= sum_new;
        count <= full ? base_cnt : base_cnt + 1'b1;
        slot  <= (slot == AW'(MAX_WINDOW - 1)) ? '0 : slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp        <= s_tdata;
      new_series <= s_tuser;
    end
    if (do_update) begin
      res_valid <= full;
      neg       <= sum_new[SUM_W-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DELIVER && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DELIVER && out_free) begin
      m_tdata <= mean_res;
      m_tuser <= res_valid;
    end
  end

endmodule

>>> rtl/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks of the moving-average block, bound to the top level.
// ----------------------------------------------------------------------------
module swm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output changed");

  // warm-up results carry a zero mean
  a_warmup_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 32'd0)
    else $error("nonzero mean on warm-up result");

  // one item at a time: no second transfer in the cycle after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in work");

  // a result cannot appear in the cycle after its input transfer
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result faster than the ring read");

endmodule

bind sliding_window_mean swm_checker u_swm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> tb/sv/sliding_window_mean_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_mean_test
// Self-checking bench for the moving-average block. A short stimulus table
// covers the window and sample extremes, warm-up, series restarts, window
// changes within a series and quotient saturation. Random phases follow,
// each at a new window length, with bursty idling on both stream sides.
// Every output transfer is compared against a scoreboard of predicted means.
// ----------------------------------------------------------------------------
module sliding_window_mean_test;
  import swm_pkg::*;

  localparam int MAX_WIN      = 256;
  localparam int ITEM_TARGET  = 1600;
  localparam int HOLD_CYCLES  = 500;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int N_ROWS       = 27;

  localparam logic [31:0] S_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] S_ONE = 32'h0001_0000;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;      // window length for ROW_CFG, sample for ROW_ITEM
    logic        start;
    logic        typed;      // expected result given in the row
    logic [31:0] exp_mean;
    logic        exp_valid;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] mean;
    logic        valid;
  } mean_exp_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  win_t        cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;      // [31:0] sample
  logic        s_tuser;      // [0] series_start
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;      // [31:0] mean
  logic        m_tuser;      // [0] mean_valid

  // predictor state
  win_t        win_len = WINDOW_RESET;
  logic [31:0] ring_mem [MAX_WIN];
  longint      run_sum = 0;
  int          seen_cnt = 0;
  int          wr_slot = 0;

  mean_exp_t   pending_means [$];
  mean_exp_t   head_exp;
  mean_exp_t   new_exp;

  // typed expectation for the item on the bus
  logic        typed_on;
  logic [31:0] typed_mean;
  logic        typed_valid;

  int          fault_cnt = 0;
  int          items_sent = 0;
  int          cycle_cnt = 0;
  logic        gappy = 1'b1;
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;

  stim_row_t dir_rows [N_ROWS] = '{
    '{ROW_ITEM, 32'h1234_5678, 1'b0, 1'b1, 32'h0,        1'b0},  // warm-up after reset
    '{ROW_CFG,  32'd0,         1'b0, 1'b0, 32'h0,        1'b0},  // zero acts as one
    '{ROW_ITEM, S_MAX,         1'b1, 1'b1, 32'h0,        1'b0},
    '{ROW_ITEM, S_MAX,         1'b0, 1'b1, S_MAX,        1'b1},
    '{ROW_ITEM, S_MIN,         1'b0, 1'b1, S_MIN,        1'b1},
    '{ROW_ITEM, 32'h0,         1'b0, 1'b1, 32'h0,        1'b1},
    '{ROW_ITEM, 32'hffff_ffff, 1'b0, 1'b1, 32'hffff_ffff, 1'b1},
    '{ROW_CFG,  32'd2,         1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ITEM, S_MAX,         1'b1, 1'b1, 32'h0,        1'b0},
    '{ROW_ITEM, S_MAX,         1'b0, 1'b1, 32'h0,        1'b0},
    '{ROW_ITEM, S_MAX,         1'b0, 1'b1, S_MAX,        1'b1},
    '{ROW_ITEM, S_MIN,         1'b0, 1'b0, 32'h0,        1'b0},  // -1/2 truncates to 0
    '{ROW_ITEM, S_MIN,         1'b0, 1'b1, S_MIN,        1'b1},
    '{ROW_ITEM, S_MAX,         1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ITEM, S_MAX,         1'b0, 1'b1, S_MAX,        1'b1},
    '{ROW_CFG,  32'd1,         1'b0, 1'b0, 32'h0,        1'b0},  // shrink mid-series
    '{ROW_ITEM, S_MAX,         1'b0, 1'b0, 32'h0,        1'b0},  // saturates high
    '{ROW_ITEM, S_MIN,         1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_CFG,  32'd2,         1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ITEM, S_MIN,         1'b1, 1'b1, 32'h0,        1'b0},
    '{ROW_ITEM, S_MIN,         1'b0, 1'b1, 32'h0,        1'b0},
    '{ROW_ITEM, S_MIN,         1'b0, 1'b1, S_MIN,        1'b1},
    '{ROW_CFG,  32'd1,         1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ITEM, S_MIN,         1'b0, 1'b0, 32'h0,        1'b0},  // saturates low
    '{ROW_CFG,  32'd4,         1'b0, 1'b0, 32'h0,        1'b0},  // grow mid-series
    '{ROW_ITEM, S_ONE,         1'b0, 1'b0, 32'h0,        1'b0},
    '{ROW_ITEM, S_ONE,         1'b1, 1'b1, 32'h0,        1'b0}
  };

  sliding_window_mean #(
    .MAX_WINDOW (MAX_WIN)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  always #4 clk = ~clk;

  initial begin
    for (int i = 0; i < MAX_WIN; i++) ring_mem[i] = '0;
  end

  function automatic int eff_window(input win_t w);
    if (w == 0) return 1;
    if (w > MAX_WIN) return MAX_WIN;
    return int'(w);
  endfunction

  function automatic void note_fault(input string msg);
    fault_cnt++;
    if (fault_cnt <= 10) $display("%s", msg);
  endfunction

  // Moving-average prediction for one accepted sample.
  function automatic mean_exp_t predict_mean(input sample_t smp, input logic restart);
    mean_exp_t r;
    int        weff;
    int        old_slot;
    longint    quot;
    weff = eff_window(win_len);
    if (restart) begin
      run_sum  = 0;
      seen_cnt = 0;
    end
    old_slot = (wr_slot - weff + MAX_WIN) % MAX_WIN;
    run_sum += longint'(smp);
    if (seen_cnt >= weff) begin
      run_sum -= longint'(sample_t'(ring_mem[old_slot]));
      r.valid = 1'b1;
    end else begin
      seen_cnt++;
      r.valid = 1'b0;
    end
    ring_mem[wr_slot] = smp;
    wr_slot = (wr_slot + 1) % MAX_WIN;
    r.mean = '0;
    if (r.valid) begin
      quot = run_sum / longint'(weff);
      if (quot > longint'($signed(MEAN_MAX))) quot = longint'($signed(MEAN_MAX));
      if (quot < longint'($signed(MEAN_MIN))) quot = longint'($signed(MEAN_MIN));
      r.mean = quot[31:0];
    end
    return r;
  endfunction

  // Scoreboard: input side first, output side second.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en) win_len = cfg_wr_data;
      if (s_tvalid && s_tready) begin
        new_exp = predict_mean(s_tdata, s_tuser);
        if (typed_on) begin
          new_exp.mean  = typed_mean;
          new_exp.valid = typed_valid;
        end
        pending_means.push_back(new_exp);
      end
      if (m_tvalid && m_tready) begin
        if (pending_means.size() == 0) begin
          note_fault($sformatf("unexpected result transfer: mean %h valid %b",
                               m_tdata, m_tuser));
        end else begin
          head_exp = pending_means.pop_front();
          if (m_tdata !== head_exp.mean || m_tuser !== head_exp.valid)
            note_fault($sformatf("mean mismatch: expected %h/%b, got %h/%b",
                                 head_exp.mean, head_exp.valid, m_tdata, m_tuser));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** sliding_window_mean: FAILED **");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        m_tready = 1'b1;
        repeat (quiet ? 1 : $urandom_range(1, 30)) @(negedge clk);
      end
    end
  end

  // Called just after a falling edge; returns on a falling edge once the
  // transfer is done, with tvalid still high.
  task automatic send_item(input logic [31:0] smp, input logic restart, input logic tp,
                           input logic [31:0] em, input logic ev);
    if (!quiet && gappy && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    s_tdata     = smp;
    s_tuser     = restart;
    typed_on    = tp;
    typed_mean  = em;
    typed_valid = ev;
    s_tvalid    = 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    s_tvalid = 1'b0;
    while (pending_means.size() != 0) @(negedge clk);
  endtask

  task automatic write_window(input win_t w);
    wait_drain();
    repeat (4) @(negedge clk);
    cfg_wr_data = w;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  initial begin
    int          phase;
    int          n_items;
    int          weff;
    win_t        w;
    logic [31:0] smp;
    logic        restart;
    win_t        fixed_wins [8];
    fixed_wins = '{9'd0, 9'd511, 9'd1, 9'd256, 9'd100, 9'd2, 9'd257, 9'd3};
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    typed_on    = 1'b0;
    typed_mean  = '0;
    typed_valid = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_window(dir_rows[i].value[8:0]);
      else
        send_item(dir_rows[i].value, dir_rows[i].start, dir_rows[i].typed,
                  dir_rows[i].exp_mean, dir_rows[i].exp_valid);
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase < 8) begin
        w = fixed_wins[phase];
      end else begin
        case ($urandom_range(0, 7))
          0:       w = 9'd0;
          1:       w = 9'd1;
          2:       w = win_t'($urandom_range(257, 511));
          3:       w = 9'd256;
          default: w = win_t'($urandom_range(2, 24));
        endcase
      end
      write_window(w);
      weff    = eff_window(w);
      n_items = weff + $urandom_range(30, 90);
      gappy   = ($urandom_range(0, 3) != 0);
      // long receiver hold-off while the sender keeps offering
      if (phase == 2) hold_req = 1'b1;
      for (int k = 0; k < n_items && items_sent < ITEM_TARGET; k++) begin
        quiet = (items_sent >= ITEM_TARGET - 200);
        // sender pause until the pipeline is empty
        if (phase == 4 && k == n_items / 2) wait_drain();
        case ($urandom_range(0, 7))
          0:       smp = S_MAX;
          1:       smp = S_MIN;
          2:       smp = '0;
          3:       smp = '1;
          4, 5:    smp = $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
          default: smp = $urandom;
        endcase
        // first item of a phase may continue the old series
        if (k == 0)
          restart = 1'($urandom_range(0, 1));
        else
          restart = ($urandom_range(0, 3 * weff + 80) == 0);
        send_item(smp, restart, 1'b0, '0, 1'b0);
      end
      phase++;
    end

    wait_drain();
    repeat (80) @(posedge clk);
    if (pending_means.size() != 0)
      note_fault($sformatf("%0d results never arrived", pending_means.size()));
    if (fault_cnt == 0) begin
      $display("** sliding_window_mean: PASSED **");
    end else begin
      $display("** sliding_window_mean: FAILED **");
    end
    $finish;
  end

endmodule

>>> sliding_window_mean.f
rtl/swm_pkg.sv
rtl/swm_ram.sv
rtl/swm_divider.sv
rtl/sliding_window_mean.sv
rtl/swm_checker.sv
tb/sv/sliding_window_mean_test.sv
